// File: src/a3ho_pkg.sv
`default_nettype none

package a3ho_pkg;

  localparam int unsigned RsrpW = 11;
  localparam int unsigned CellW = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HystW = 8;
  localparam int unsigned TttW  = 16;
  localparam int unsigned CfgW  = 16;

  // -140 dBm in quarter dBm
  localparam logic signed [RsrpW-1:0] RSRP_FLOOR = -11'sd560;

  localparam logic [HystW-1:0] HYST_RST = 8'd12;
  localparam logic [TttW-1:0]  TTT_RST  = 16'd160;

  localparam logic OP_MEAS = 1'b0;
  localparam logic OP_HO   = 1'b1;

  localparam logic CFG_HYST = 1'b0;
  localparam logic CFG_TTT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HO_RD,
    ST_HO_SET,
    ST_SCAN,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: src/a3_handover_decision_ttt.sv
// sequence: a measurement request scans every table entry before its result is offered,
//   a handover command passes ST_HO_RD and ST_HO_SET, an ignored one goes straight to ST_OUT
// one request at a time: a new request is taken only after the result has been taken;
//   the scan reads one table entry per cycle through a single memory read port
// reset: async active low; serving cell 0 at -140 dBm, all table entries read as -140 dBm,
//   no pending marks, hysteresis 12, time-to-trigger 160 ms
`default_nettype none

module a3_handover_decision_ttt #(
  parameter int NUM_CELLS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire                         cfg_addr_i,
  input  wire  [a3ho_pkg::CfgW-1:0]   cfg_wdata_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         op_i,
  input  wire  [a3ho_pkg::CellW-1:0]  cell_index_i,
  input  wire  signed [a3ho_pkg::RsrpW-1:0] rsrp_i,
  input  wire  [a3ho_pkg::TimeW-1:0]  timestamp_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        handover_wanted_o,
  output logic [a3ho_pkg::CellW-1:0]  target_cell_o,
  output logic signed [a3ho_pkg::RsrpW-1:0] target_rsrp_o,
  output logic [a3ho_pkg::CellW-1:0]  serving_cell_o,
  output logic signed [a3ho_pkg::RsrpW-1:0] serving_rsrp_o,
  output logic                        handover_done_o
);

  localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int XW = (CW > a3ho_pkg::CellW) ? CW : a3ho_pkg::CellW;

  a3ho_pkg::state_e state_q, state_d;

  logic [a3ho_pkg::HystW-1:0] hyst_q;
  logic [a3ho_pkg::TttW-1:0]  ttt_q;

  logic [a3ho_pkg::CellW-1:0]        serv_q;
  logic signed [a3ho_pkg::RsrpW-1:0] serv_lvl_q;
  logic [NUM_CELLS-1:0]              pend_q;
  logic [NUM_CELLS-1:0]              rsrp_vld_q;

  logic signed [a3ho_pkg::RsrpW-1:0] rsrp_mem [NUM_CELLS];
  logic [a3ho_pkg::TimeW-1:0]        fs_mem [NUM_CELLS];

  logic signed [a3ho_pkg::RsrpW-1:0] rd_rsrp_q;
  logic                              rd_vld_q;
  logic [a3ho_pkg::TimeW-1:0]        rd_fs_q;

  logic [CW-1:0]                     cnt_q;
  logic                              issue_done_q;
  logic                              eval_vld_q;
  logic [CW-1:0]                     eval_idx_q;

  logic [a3ho_pkg::TimeW-1:0]        now_q;
  logic [a3ho_pkg::CellW-1:0]        ho_idx_q;
  logic                              best_vld_q;
  logic [a3ho_pkg::CellW-1:0]        best_idx_q;
  logic signed [a3ho_pkg::RsrpW-1:0] best_lvl_q;
  logic                              done_q;

  logic          in_acc;
  logic          in_rng;
  logic          is_ho;
  logic          tbl_we;
  logic          srv_refresh;
  logic          ho_ok;
  logic          ho_rd;
  logic          ho_set;
  logic          issue;
  logic          eval_last;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] in_addr;
  logic [CW-1:0] ho_addr;

  logic signed [a3ho_pkg::RsrpW-1:0] cur_rsrp;
  logic signed [a3ho_pkg::RsrpW-1:0] best_ref;
  logic signed [a3ho_pkg::RsrpW+1:0] bar;
  logic [a3ho_pkg::TimeW-1:0]        elapsed;
  logic          is_srv;
  logic          cond;
  logic          newly;
  logic          ttt_ok;
  logic          stronger;

  // request decode
  assign in_acc  = in_valid_i && in_ready_o;
  assign in_rng  = 32'(cell_index_i) < NUM_CELLS;
  assign is_ho   = op_i == a3ho_pkg::OP_HO;
  assign in_addr = CW'(cell_index_i);
  assign ho_addr = CW'(ho_idx_q);
  assign ho_ok   = in_rng && (cell_index_i != serv_q);
  assign tbl_we  = in_acc && !is_ho && in_rng && (rsrp_i > a3ho_pkg::RSRP_FLOOR);
  assign srv_refresh = tbl_we && (cell_index_i == serv_q);

  assign issue     = (state_q == a3ho_pkg::ST_SCAN) && !issue_done_q;
  assign eval_last = eval_idx_q == CW'(NUM_CELLS - 1);
  assign rd_addr   = ho_rd ? ho_addr : cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      a3ho_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!is_ho) state_d = a3ho_pkg::ST_SCAN;
          else if (ho_ok) state_d = a3ho_pkg::ST_HO_RD;
          else state_d = a3ho_pkg::ST_OUT;
        end
      end
      a3ho_pkg::ST_HO_RD:  state_d = a3ho_pkg::ST_HO_SET;
      a3ho_pkg::ST_HO_SET: state_d = a3ho_pkg::ST_OUT;
      a3ho_pkg::ST_SCAN: begin
        if (eval_vld_q && eval_last) state_d = a3ho_pkg::ST_OUT;
      end
      a3ho_pkg::ST_OUT: begin
        if (out_ready_i) state_d = a3ho_pkg::ST_IDLE;
      end
      default: state_d = a3ho_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ho_rd       = 1'b0;
    ho_set      = 1'b0;
    unique case (state_q)
      a3ho_pkg::ST_IDLE:   in_ready_o  = 1'b1;
      a3ho_pkg::ST_HO_RD:  ho_rd       = 1'b1;
      a3ho_pkg::ST_HO_SET: ho_set      = 1'b1;
      a3ho_pkg::ST_SCAN:   ;
      a3ho_pkg::ST_OUT:    out_valid_o = 1'b1;
      default:             ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= a3ho_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= a3ho_pkg::HYST_RST;
      ttt_q  <= a3ho_pkg::TTT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        a3ho_pkg::CFG_HYST: hyst_q <= cfg_wdata_i[a3ho_pkg::HystW-1:0];
        a3ho_pkg::CFG_TTT:  ttt_q  <= cfg_wdata_i[a3ho_pkg::TttW-1:0];
        default:            ;
      endcase
    end
  end

  // table memories, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (tbl_we) rsrp_mem[in_addr] <= rsrp_i;
    rd_rsrp_q <= rsrp_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (eval_vld_q && !is_srv && cond && newly) fs_mem[eval_idx_q] <= now_q;
    rd_fs_q <= fs_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsrp_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (tbl_we) rsrp_vld_q[in_addr] <= 1'b1;
      rd_vld_q <= rsrp_vld_q[rd_addr];
    end
  end

  // scan evaluation of the entry read in the previous cycle
  assign cur_rsrp = rd_vld_q ? rd_rsrp_q : a3ho_pkg::RSRP_FLOOR;
  assign best_ref = best_vld_q ? best_lvl_q : serv_lvl_q;
  assign bar      = (a3ho_pkg::RsrpW + 2)'(serv_lvl_q)
                  + $signed({{(a3ho_pkg::RsrpW + 2 - a3ho_pkg::HystW){1'b0}}, hyst_q});
  assign is_srv   = XW'(eval_idx_q) == XW'(serv_q);
  assign cond     = (a3ho_pkg::RsrpW + 2)'(cur_rsrp) > bar;
  assign newly    = !pend_q[eval_idx_q];
  assign elapsed  = now_q - rd_fs_q;
  assign ttt_ok   = newly ? (ttt_q == '0) : (elapsed >= a3ho_pkg::TimeW'(ttt_q));
  assign stronger = cur_rsrp > best_ref;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (ho_set) begin
      pend_q[ho_addr] <= 1'b0;
    end else if (eval_vld_q && !is_srv) begin
      pend_q[eval_idx_q] <= cond;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serv_q     <= '0;
      serv_lvl_q <= a3ho_pkg::RSRP_FLOOR;
    end else if (srv_refresh) begin
      serv_lvl_q <= rsrp_i;
    end else if (ho_set) begin
      serv_q     <= ho_idx_q;
      serv_lvl_q <= cur_rsrp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      issue_done_q <= 1'b0;
      eval_vld_q   <= 1'b0;
      best_vld_q   <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      eval_vld_q <= issue;
      if (in_acc) begin
        cnt_q        <= '0;
        issue_done_q <= 1'b0;
        best_vld_q   <= 1'b0;
        done_q       <= 1'b0;
      end else begin
        if (issue) begin
          if (cnt_q == CW'(NUM_CELLS - 1)) issue_done_q <= 1'b1;
          else cnt_q <= cnt_q + CW'(1);
        end
        if (eval_vld_q && !is_srv && cond && ttt_ok && stronger) best_vld_q <= 1'b1;
        if (ho_set) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= timestamp_i;
      ho_idx_q <= cell_index_i;
    end
    if (issue) eval_idx_q <= cnt_q;
    if (eval_vld_q && !is_srv && cond && ttt_ok && stronger) begin
      best_idx_q <= a3ho_pkg::CellW'(eval_idx_q);
      best_lvl_q <= cur_rsrp;
    end
  end

  assign handover_wanted_o = best_vld_q;
  assign target_cell_o     = best_vld_q ? best_idx_q : '0;
  assign target_rsrp_o     = best_vld_q ? best_lvl_q : '0;
  assign serving_cell_o    = serv_q;
  assign serving_rsrp_o    = serv_lvl_q;
  assign handover_done_o   = done_q;

endmodule

`default_nettype wire

// File: src/a3ho_chk.sv
`default_nettype none

module a3ho_chk (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_o,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire                        handover_wanted_o,
  input wire [a3ho_pkg::CellW-1:0]  target_cell_o,
  input wire [a3ho_pkg::RsrpW-1:0]  target_rsrp_o,
  input wire [a3ho_pkg::CellW-1:0]  serving_cell_o,
  input wire [a3ho_pkg::RsrpW-1:0]  serving_rsrp_o,
  input wire                        handover_done_o
);

  // a waiting result keeps its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_cell_o)
      && $stable(target_rsrp_o) && $stable(serving_cell_o) && $stable(serving_rsrp_o)
      && $stable(handover_wanted_o) && $stable(handover_done_o))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // after the result is taken the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o && !out_valid_o)
    else $error("not ready after result");

  // a handover command never recommends a target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && handover_done_o |-> !handover_wanted_o)
    else $error("target on handover command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !handover_wanted_o |-> target_cell_o == '0 && target_rsrp_o == '0)
    else $error("target fields not cleared");

endmodule

bind a3_handover_decision_ttt a3ho_chk u_chk (.*);

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELL = 16;
  localparam int FloorQ = a3ho_pkg::RSRP_FLOOR;
  localparam int CycleLimit = 500000;
  localparam int HoldLen = 300;

  typedef struct packed {
    logic                              wanted;
    logic [a3ho_pkg::CellW-1:0]        target;
    logic signed [a3ho_pkg::RsrpW-1:0] target_rsrp;
    logic [a3ho_pkg::CellW-1:0]        serving;
    logic signed [a3ho_pkg::RsrpW-1:0] serving_rsrp;
    logic                              done;
  } decision_t;

  // tracks the cell table and predicts one decision per accepted request
  class handover_tracker;
    int           level [NCELL];
    bit           marked [NCELL];
    logic [31:0]  first_seen [NCELL];
    int           serving_idx;
    int           serving_lvl;
    int           hyst;
    int           ttt;
    bit           last_wanted;
    int           last_target;
    decision_t    decisions_due[$];
    int           mismatches;

    function new();
      for (int c = 0; c < NCELL; c++) begin
        level[c] = FloorQ;
        marked[c] = 1'b0;
        first_seen[c] = '0;
      end
      serving_idx = 0;
      serving_lvl = FloorQ;
      hyst = int'(a3ho_pkg::HYST_RST);
      ttt = int'(a3ho_pkg::TTT_RST);
      last_wanted = 1'b0;
      last_target = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic addr, logic [a3ho_pkg::CfgW-1:0] data);
      if (addr == a3ho_pkg::CFG_HYST) hyst = int'(data[a3ho_pkg::HystW-1:0]);
      else ttt = int'(data[a3ho_pkg::TttW-1:0]);
    endfunction

    function void take_request(logic op, logic [a3ho_pkg::CellW-1:0] idx,
                               logic signed [a3ho_pkg::RsrpW-1:0] rsrp,
                               logic [a3ho_pkg::TimeW-1:0] ts);
      decision_t   d;
      int          lv;
      int          bar;
      int          best;
      int          c;
      logic [31:0] elapsed;
      d = '0;
      lv = int'(rsrp);
      if (op == a3ho_pkg::OP_HO) begin
        if (idx < NCELL && idx != serving_idx) begin
          serving_idx = int'(idx);
          serving_lvl = level[idx];
          marked[idx] = 1'b0;
          d.done = 1'b1;
        end
      end else begin
        if (idx < NCELL) begin
          if (lv > FloorQ) level[idx] = lv;
          if (idx == serving_idx) serving_lvl = level[idx];
        end
        bar = serving_lvl + hyst;
        best = serving_lvl;
        for (c = 0; c < NCELL; c++) begin
          if (c != serving_idx) begin
            if (level[c] > bar) begin
              if (!marked[c]) begin
                marked[c] = 1'b1;
                first_seen[c] = ts;
              end
              elapsed = ts - first_seen[c];
              if (elapsed >= ttt && level[c] > best) begin
                best = level[c];
                d.wanted = 1'b1;
                d.target = c[a3ho_pkg::CellW-1:0];
                d.target_rsrp = level[c][a3ho_pkg::RsrpW-1:0];
              end
            end else begin
              marked[c] = 1'b0;
            end
          end
        end
      end
      d.serving = serving_idx[a3ho_pkg::CellW-1:0];
      d.serving_rsrp = serving_lvl[a3ho_pkg::RsrpW-1:0];
      last_wanted = d.wanted;
      last_target = int'(d.target);
      decisions_due = {decisions_due, d};
    endfunction

    function void check_decision(decision_t got);
      decision_t exp;
      if (decisions_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected decision: wanted=%0d target=%0d serving=%0d done=%0d",
                 $time, got.wanted, got.target, got.serving, got.done);
        return;
      end
      exp = decisions_due.pop_front();
      if (got !== exp) begin
        mismatches++;
        $display("%0t: decision mismatch, expected wanted=%0d target=%0d tgt_rsrp=%0d %s",
                 $time, exp.wanted, exp.target, exp.target_rsrp, "");
        $display("%0t:   expected serving=%0d srv_rsrp=%0d done=%0d",
                 $time, exp.serving, exp.serving_rsrp, exp.done);
        $display("%0t:   actual wanted=%0d target=%0d tgt_rsrp=%0d",
                 $time, got.wanted, got.target, got.target_rsrp);
        $display("%0t:   actual serving=%0d srv_rsrp=%0d done=%0d",
                 $time, got.serving, got.serving_rsrp, got.done);
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic                              cfg_addr_i = a3ho_pkg::CFG_HYST;
  logic [a3ho_pkg::CfgW-1:0]         cfg_wdata_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic                              op_i = a3ho_pkg::OP_MEAS;
  logic [a3ho_pkg::CellW-1:0]        cell_index_i = '0;
  logic signed [a3ho_pkg::RsrpW-1:0] rsrp_i = '0;
  logic [a3ho_pkg::TimeW-1:0]        timestamp_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              handover_wanted_o;
  logic [a3ho_pkg::CellW-1:0]        target_cell_o;
  logic signed [a3ho_pkg::RsrpW-1:0] target_rsrp_o;
  logic [a3ho_pkg::CellW-1:0]        serving_cell_o;
  logic signed [a3ho_pkg::RsrpW-1:0] serving_rsrp_o;
  logic                              handover_done_o;

  handover_tracker tracker;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_used = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [31:0] now_ms = '0;

  int hyst_plan[8] = '{0, 255, 8, 20, 0, 255, 12, 4};
  int ttt_plan[8]  = '{0, 65535, 40, 100, 65535, 0, 160, 20};

  a3_handover_decision_ttt #(
    .NUM_CELLS(NCELL)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .cell_index_i     (cell_index_i),
    .rsrp_i           (rsrp_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .handover_wanted_o(handover_wanted_o),
    .target_cell_o    (target_cell_o),
    .target_rsrp_o    (target_rsrp_o),
    .serving_cell_o   (serving_cell_o),
    .serving_rsrp_o   (serving_rsrp_o),
    .handover_done_o  (handover_done_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("a3_handover_decision_ttt test failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_decision('{handover_wanted_o, target_cell_o, target_rsrp_o,
                               serving_cell_o, serving_rsrp_o, handover_done_o});
  end

  task automatic send_request(input logic op, input logic [a3ho_pkg::CellW-1:0] idx,
                              input logic signed [a3ho_pkg::RsrpW-1:0] rsrp,
                              input logic [a3ho_pkg::TimeW-1:0] ts);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    cell_index_i <= idx;
    rsrp_i       <= rsrp;
    timestamp_i  <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_request(op, idx, rsrp, ts);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (tracker.decisions_due.size() != 0) @(posedge clk_i);
    repeat (NCELL + 4) @(posedge clk_i);
  endtask

  task automatic set_config(input int hyst, input int ttt);
    logic [a3ho_pkg::CfgW-1:0] hyst_word;
    hyst_word = {8'($urandom), 8'(hyst)};
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= a3ho_pkg::CFG_HYST;
    cfg_wdata_i <= hyst_word;
    @(posedge clk_i);
    tracker.write_reg(a3ho_pkg::CFG_HYST, hyst_word);
    cfg_addr_i  <= a3ho_pkg::CFG_TTT;
    cfg_wdata_i <= ttt[a3ho_pkg::CfgW-1:0];
    @(posedge clk_i);
    tracker.write_reg(a3ho_pkg::CFG_TTT, ttt[a3ho_pkg::CfgW-1:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_request();
    int                         roll;
    int                         tmp;
    logic [a3ho_pkg::CellW-1:0] idx;
    logic [31:0]                noise;
    roll = $urandom_range(99);
    if (roll < 12) begin
      // handover, mostly to the recommended target
      if (tracker.last_wanted && $urandom_range(99) < 70)
        idx = a3ho_pkg::CellW'(tracker.last_target);
      else idx = a3ho_pkg::CellW'($urandom_range(NCELL - 1));
      noise = $urandom;
      send_request(a3ho_pkg::OP_HO, idx, noise[a3ho_pkg::RsrpW-1:0], $urandom);
    end else begin
      if ($urandom_range(99) < 25) idx = a3ho_pkg::CellW'(tracker.serving_idx);
      else idx = a3ho_pkg::CellW'($urandom_range(NCELL - 1));
      roll = $urandom_range(99);
      if (roll < 10) tmp = $urandom;
      else if (roll < 20) tmp = FloorQ - 2 + $urandom_range(4);
      else tmp = FloorQ + $urandom_range(700);
      roll = $urandom_range(99);
      if (roll < 3) now_ms = now_ms + $urandom;
      else if (roll >= 13) now_ms = now_ms + $urandom_range(1, 40);
      send_request(a3ho_pkg::OP_MEAS, idx, tmp[a3ho_pkg::RsrpW-1:0], now_ms);
    end
  endtask

  initial begin
    int phase_no;
    int n;
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: hysteresis 12, time-to-trigger 160
    send_request(a3ho_pkg::OP_MEAS, 4'd0, -11'sd1024, 32'd0);    // below floor, serving level not refreshed
    send_request(a3ho_pkg::OP_MEAS, 4'd3, 11'sd1023, 32'd0);
    send_request(a3ho_pkg::OP_MEAS, 4'd5, -11'sd560, 32'd10);    // exactly at floor
    send_request(a3ho_pkg::OP_MEAS, 4'd5, -11'sd559, 32'd20);
    send_request(a3ho_pkg::OP_MEAS, 4'd0, -11'sd700, 32'd30);
    send_request(a3ho_pkg::OP_MEAS, 4'd3, 11'sd1023, 32'd160);   // trigger time just reached
    send_request(a3ho_pkg::OP_MEAS, 4'd6, 11'sd1023, 32'd170);   // newly above the bar, trigger time not yet reached
    send_request(a3ho_pkg::OP_HO, 4'd0, 11'sd1023, 32'hFFFF_FFFF); // already serving
    send_request(a3ho_pkg::OP_HO, 4'd3, -11'sd1024, 32'd0);
    send_request(a3ho_pkg::OP_MEAS, 4'd6, 11'sd1023, 32'd330);
    send_request(a3ho_pkg::OP_MEAS, 4'd3, -11'sd400, 32'd340);
    send_request(a3ho_pkg::OP_MEAS, 4'd9, -11'sd200, 32'd400);
    send_request(a3ho_pkg::OP_MEAS, 4'd9, -11'sd200, 32'd500);
    send_request(a3ho_pkg::OP_HO, 4'd6, 11'sd0, 32'd0);
    send_request(a3ho_pkg::OP_HO, 4'd6, 11'sd5, 32'd7);
    send_request(a3ho_pkg::OP_MEAS, 4'd6, 11'sd0, 32'hFFFF_FF80);
    send_request(a3ho_pkg::OP_MEAS, 4'd12, 11'sd100, 32'hFFFF_FFF0);
    send_request(a3ho_pkg::OP_MEAS, 4'd12, 11'sd100, 32'h0000_0090); // elapsed across the wrap
    send_request(a3ho_pkg::OP_MEAS, 4'd15, 11'sd1023, 32'h0000_0090);
    send_request(a3ho_pkg::OP_MEAS, 4'd0, 11'sd0, 32'h0000_00A0);    // equal to serving level
    now_ms = 32'h0000_00A0;
    drain_requests();

    for (phase_no = 0; phase_no < 8; phase_no++) begin
      set_config(hyst_plan[phase_no], ttt_plan[phase_no]);
      case (phase_no % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (phase_no == 4) hold_req = 1'b1;
      for (n = 0; n < 104; n++) begin
        if (phase_no == 5 && n == 50) drain_requests();
        send_random_request();
      end
      drain_requests();
    end

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (NCELL * 2 + 8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.decisions_due.size() == 0) begin
      $display("a3_handover_decision_ttt test passed");
    end else begin
      $display("a3_handover_decision_ttt test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/a3ho_pkg.sv
src/a3_handover_decision_ttt.sv
src/a3ho_chk.sv
tb/testbench.sv
